// ===== hdl/twd_pkg.sv =====
// Package: shared types, codes and defaults of the tagged work item deque.
`timescale 1ns / 1ps
package twd_pkg;

	localparam int TWD_MAX_DEPTH = 256;
	localparam int TWD_WORD_BITS = 32;

	localparam int ADDR_W = 3;
	localparam logic CFG_IDX_CAPACITY = 1'b0;
	localparam logic [8:0] CAPACITY_RESET = 9'd256;

	localparam logic [2:0] KIND_PUSH_BACK = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK_ARG = 3'd1;
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd2;
	localparam logic [2:0] KIND_PUSH_FRONT_ARG = 3'd3;

	typedef enum logic [2:0] {
		OP_PUSH_BACK,
		OP_PUSH_BACK_ARG,
		OP_PUSH_FRONT,
		OP_PUSH_FRONT_ARG,
		OP_SCHEDULE
	} twd_op_t;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_DISPATCHED = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL = 2'd3
	} twd_status_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_PUSH2,
		BS_POP1,
		BS_POP2
	} twd_state_t;

	typedef struct packed {
		twd_status_t status;
		logic [30:0] handle;
		logic signed [31:0] argument;
		logic has_argument;
		logic [8:0] occupancy;
	} twd_result_t;

endpackage

// ===== hdl/twd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module twd_ram import twd_pkg::*; #(
	parameter int WIDTH = TWD_WORD_BITS,
	parameter int DEPTH = TWD_MAX_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/twd_front.sv =====
// Front end: decodes the request kind and formats the ring words of an item.
`timescale 1ns / 1ps
module twd_front import twd_pkg::*; #(
	parameter int WORD_BITS = TWD_WORD_BITS
) (
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [2:0]           kind,
	input  logic [30:0]          fn_handle,
	input  logic signed [31:0]   argument,
	output logic                 q_valid,
	input  logic                 q_stall,
	output twd_op_t              q_op,
	output logic [WORD_BITS-1:0] q_word_a,
	output logic [WORD_BITS-1:0] q_word_b
);

	logic [31:0]          arg_bits;
	logic [WORD_BITS-1:0] fn_word;
	logic [WORD_BITS-1:0] tag_word;
	logic [WORD_BITS-1:0] arg_word;

	assign arg_bits = argument;
	assign fn_word  = WORD_BITS'(64'(fn_handle));
	assign tag_word = '0 - fn_word;
	assign arg_word = WORD_BITS'(64'(arg_bits));

	assign q_valid   = req_valid;
	assign req_stall = q_stall;

	// word_a goes to the ring first; front pushes write argument, then tag before it
	always_comb begin
		q_op     = OP_SCHEDULE;
		q_word_a = fn_word;
		q_word_b = arg_word;
		unique case (kind)
			KIND_PUSH_BACK: begin
				q_op = OP_PUSH_BACK;
			end
			KIND_PUSH_BACK_ARG: begin
				q_op     = OP_PUSH_BACK_ARG;
				q_word_a = tag_word;
				q_word_b = arg_word;
			end
			KIND_PUSH_FRONT: begin
				q_op = OP_PUSH_FRONT;
			end
			KIND_PUSH_FRONT_ARG: begin
				q_op     = OP_PUSH_FRONT_ARG;
				q_word_a = arg_word;
				q_word_b = tag_word;
			end
			default: begin
				q_op = OP_SCHEDULE;
			end
		endcase
	end

endmodule

// ===== hdl/twd_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module twd_queue import twd_pkg::*; #(
	parameter int WORD_BITS = TWD_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  twd_op_t              in_op,
	input  logic [WORD_BITS-1:0] in_word_a,
	input  logic [WORD_BITS-1:0] in_word_b,
	output logic                 out_valid,
	input  logic                 out_stall,
	output twd_op_t              out_op,
	output logic [WORD_BITS-1:0] out_word_a,
	output logic [WORD_BITS-1:0] out_word_b
);

	twd_op_t              op_q     [2];
	logic [WORD_BITS-1:0] word_a_q [2];
	logic [WORD_BITS-1:0] word_b_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 push;
	logic                 pop;

	assign in_stall  = (fill_q == 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	assign out_op     = op_q[rd_ptr_q];
	assign out_word_a = word_a_q[rd_ptr_q];
	assign out_word_b = word_b_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]     <= in_op;
			word_a_q[wr_ptr_q] <= in_word_a;
			word_b_q[wr_ptr_q] <= in_word_b;
		end
	end

endmodule

// ===== hdl/twd_back.sv =====
// Back end: ring memory, head/count bookkeeping, pop decode and result register.
`timescale 1ns / 1ps
module twd_back import twd_pkg::*; #(
	parameter int MAX_DEPTH = TWD_MAX_DEPTH,
	parameter int WORD_BITS = TWD_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [8:0]           capacity,
	input  logic                 q_valid,
	output logic                 q_stall,
	input  twd_op_t              q_op,
	input  logic [WORD_BITS-1:0] q_word_a,
	input  logic [WORD_BITS-1:0] q_word_b,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output twd_result_t          res
);

	localparam int IDX_W = $clog2(MAX_DEPTH);
	localparam int CNT_W = $clog2(MAX_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	twd_state_t           state_q, state_d;
	logic [IDX_W-1:0]     head_q, head_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic                 out_valid_q, out_valid_d;
	twd_result_t          res_q, res_d;
	logic [WORD_BITS-1:0] second_q, second_d;
	logic                 front_q, front_d;
	logic [30:0]          handle_q, handle_d;
	logic                 load_res;
	logic                 q_take;

	logic [CNT_W-1:0]     cap_eff;
	logic [SUM_W-1:0]     tail_sum;
	logic [IDX_W-1:0]     tail_idx;
	logic [IDX_W-1:0]     prev_idx;
	logic [IDX_W-1:0]     next_idx;
	logic                 head_big;
	logic                 out_free;
	logic                 op_two;
	logic                 op_front;
	logic                 op_fits;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] neg_word;
	logic                 rd_plain;
	logic [63:0]          h_ext;
	logic [63:0]          a_ext;

	twd_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAX_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(rd_word)
	);

	always_comb begin
		if (capacity < 9'd2) begin
			cap_eff = CNT_W'(2);
		end else if (capacity > 9'(MAX_DEPTH)) begin
			cap_eff = CNT_W'(MAX_DEPTH);
		end else begin
			cap_eff = CNT_W'(capacity);
		end
	end

	// head < cap and count <= cap here, so one compare-subtract wraps the tail
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_idx = (tail_sum >= SUM_W'(cap_eff)) ? IDX_W'(tail_sum - SUM_W'(cap_eff))
	                                                : IDX_W'(tail_sum);
	assign prev_idx = (head_q == '0) ? IDX_W'(cap_eff - 1'b1) : head_q - 1'b1;
	assign next_idx = ((CNT_W'(head_q) + 1'b1) == cap_eff) ? '0 : head_q + 1'b1;
	assign head_big = (CNT_W'(head_q) >= cap_eff);
	assign out_free = !out_valid_q || !rsp_stall;

	assign op_two   = (q_op == OP_PUSH_BACK_ARG) || (q_op == OP_PUSH_FRONT_ARG);
	assign op_front = (q_op == OP_PUSH_FRONT) || (q_op == OP_PUSH_FRONT_ARG);
	assign op_fits  = (SUM_W'(count_q) + (op_two ? SUM_W'(2) : SUM_W'(1))) <= SUM_W'(cap_eff);

	// head word decode: positive word is a plain handle, else negated handle
	assign neg_word = '0 - rd_word;
	assign rd_plain = (rd_word != '0) && !rd_word[WORD_BITS-1];
	assign h_ext    = rd_plain ? 64'(rd_word) : 64'(neg_word);
	assign a_ext    = 64'(signed'(rd_word));

	assign q_stall = !q_take;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		second_d  = second_q;
		front_d   = front_q;
		handle_d  = handle_q;
		q_take    = 1'b0;
		load_res  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = tail_idx;
		ram_wdata = q_word_a;
		ram_re    = 1'b0;
		res_d     = '0;
		res_d.status = ST_PUSHED;

		unique case (state_q)
			BS_IDLE: begin
				if (head_big) begin
					// realign head after a capacity change, one subtract a cycle
					head_d = IDX_W'(CNT_W'(head_q) - cap_eff);
				end else if (q_valid) begin
					if (q_op == OP_SCHEDULE) begin
						if (count_q == '0) begin
							if (out_free) begin
								q_take       = 1'b1;
								load_res     = 1'b1;
								res_d.status = ST_EMPTY;
							end
						end else begin
							q_take  = 1'b1;
							ram_re  = 1'b1;
							head_d  = next_idx;
							count_d = count_q - 1'b1;
							state_d = BS_POP1;
						end
					end else if (!op_fits) begin
						if (out_free) begin
							q_take       = 1'b1;
							load_res     = 1'b1;
							res_d.status = ST_FULL;
						end
					end else if (op_two || out_free) begin
						q_take    = 1'b1;
						ram_we    = 1'b1;
						ram_waddr = op_front ? prev_idx : tail_idx;
						ram_wdata = q_word_a;
						count_d   = count_q + 1'b1;
						if (op_front) begin
							head_d = prev_idx;
						end
						if (op_two) begin
							second_d = q_word_b;
							front_d  = op_front;
							state_d  = BS_PUSH2;
						end else begin
							load_res = 1'b1;
						end
					end
				end
			end
			BS_PUSH2: begin
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = front_q ? prev_idx : tail_idx;
					ram_wdata = second_q;
					count_d   = count_q + 1'b1;
					if (front_q) begin
						head_d = prev_idx;
					end
					load_res = 1'b1;
					state_d  = BS_IDLE;
				end
			end
			BS_POP1: begin
				if (!rd_plain && (count_q != '0)) begin
					ram_re   = 1'b1;
					head_d   = next_idx;
					count_d  = count_q - 1'b1;
					handle_d = h_ext[30:0];
					state_d  = BS_POP2;
				end else if (out_free) begin
					load_res     = 1'b1;
					res_d.status = ST_DISPATCHED;
					res_d.handle = h_ext[30:0];
					state_d      = BS_IDLE;
				end
			end
			BS_POP2: begin
				if (out_free) begin
					load_res           = 1'b1;
					res_d.status       = ST_DISPATCHED;
					res_d.handle       = handle_q;
					res_d.argument     = a_ext[31:0];
					res_d.has_argument = 1'b1;
					state_d            = BS_IDLE;
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase

		res_d.occupancy = 9'(count_d);

		if (load_res) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !rsp_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		second_q <= second_d;
		front_q  <= front_d;
		handle_q <= handle_d;
		if (load_res) begin
			res_q <= res_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign res       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_DEPTH))
		else $error("word count above ring depth");

	a_head_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BS_IDLE) |-> (CNT_W'(head_q) < cap_eff))
		else $error("head outside capacity while an item is in progress");

	a_pop2_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_POP2) |-> (($past(state_q) == BS_POP1) || ($past(state_q) == BS_POP2)))
		else $error("argument read without a head word read");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.status == ST_EMPTY)) |-> (res_q.occupancy == 9'd0))
		else $error("empty result with words held");

	a_arg_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.has_argument) |-> (res_q.status == ST_DISPATCHED))
		else $error("argument flag on a result that dispatched nothing");

endmodule

// ===== hdl/tagged_work_item_deque_top.sv =====
// Top level of the tagged work item deque: config register and block wiring.
//
// Request channel (req_valid/req_stall, kind, fn_handle, argument) takes push
// back, push front (each with or without an argument word) and schedule items.
// Response channel (rsp_valid/rsp_stall) returns one result per item: status,
// dispatched handle and argument, has_argument and the ring occupancy after it.
// The capacity register (APB, address 0) sets the ring wrap point; write it
// only while the block is idle.
// Plain pushes, refusals and empty schedules finish in the idle state; pushes
// with an argument pass through PUSH2, pops through POP1, and pops that carry
// an argument through POP1 and POP2. The back end handles one item at a time,
// bound by the single write and single read port of the ring RAM.
// A two-entry queue decouples request acceptance from the back end.
// After a capacity change the head index is realigned one subtraction per
// cycle before the next item runs.
// Reset empties the ring and sets capacity to 256; ring contents stay as is.
// When rsp_stall is high the result is held and the back end waits before
// finishing the next item; the queue then fills and req_stall rises.
`timescale 1ns / 1ps
module tagged_work_item_deque_top import twd_pkg::*; #(
	parameter int MAX_DEPTH = TWD_MAX_DEPTH,
	parameter int WORD_BITS = TWD_WORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         kind,
	input  logic [30:0]        fn_handle,
	input  logic signed [31:0] argument,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [30:0]        out_handle,
	output logic signed [31:0] out_argument,
	output logic               has_argument,
	output logic [8:0]         occupancy
);

	logic [8:0]           capacity_q;
	logic                 cfg_write;
	logic                 fq_valid;
	logic                 fq_stall;
	twd_op_t              fq_op;
	logic [WORD_BITS-1:0] fq_word_a;
	logic [WORD_BITS-1:0] fq_word_b;
	logic                 qb_valid;
	logic                 qb_stall;
	twd_op_t              qb_op;
	logic [WORD_BITS-1:0] qb_word_a;
	logic [WORD_BITS-1:0] qb_word_b;
	twd_result_t          res;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
	                   && (paddr[ADDR_W-1] == CFG_IDX_CAPACITY);
	assign prdata    = (paddr[ADDR_W-1] == CFG_IDX_CAPACITY) ? 32'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_write) begin
			capacity_q <= pwdata[8:0];
		end
	end

	twd_front #(
		.WORD_BITS(WORD_BITS)
	) u_front (
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind     (kind),
		.fn_handle(fn_handle),
		.argument (argument),
		.q_valid  (fq_valid),
		.q_stall  (fq_stall),
		.q_op     (fq_op),
		.q_word_a (fq_word_a),
		.q_word_b (fq_word_b)
	);

	twd_queue #(
		.WORD_BITS(WORD_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_stall  (fq_stall),
		.in_op     (fq_op),
		.in_word_a (fq_word_a),
		.in_word_b (fq_word_b),
		.out_valid (qb_valid),
		.out_stall (qb_stall),
		.out_op    (qb_op),
		.out_word_a(qb_word_a),
		.out_word_b(qb_word_b)
	);

	twd_back #(
		.MAX_DEPTH(MAX_DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.q_valid  (qb_valid),
		.q_stall  (qb_stall),
		.q_op     (qb_op),
		.q_word_a (qb_word_a),
		.q_word_b (qb_word_b),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.res      (res)
	);

	assign status       = res.status;
	assign out_handle   = res.handle;
	assign out_argument = res.argument;
	assign has_argument = res.has_argument;
	assign occupancy    = res.occupancy;

endmodule

// ===== tb/sv/twd_checker.sv =====
// Checker: tracks the deque state from accepted items and compares every result.
`timescale 1ns / 1ps
module twd_checker import twd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [2:0]         kind,
	input  logic [30:0]        fn_handle,
	input  logic [31:0]        argument,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic [1:0]         status,
	input  logic [30:0]        out_handle,
	input  logic [31:0]        out_argument,
	input  logic               has_argument,
	input  logic [8:0]         occupancy,
	output int                 fail_count,
	output int                 pending
);

	logic [31:0] ring [TWD_MAX_DEPTH];
	int unsigned head;
	int unsigned words;
	logic [8:0] capacity;
	twd_result_t results_q[$];
	twd_result_t want;
	int errs;

	function automatic void put_back(int unsigned cap, logic [31:0] w);
		ring[(head + words) % cap] = w;
		words++;
	endfunction

	function automatic void put_front(int unsigned cap, logic [31:0] w);
		head = (head + cap - 1) % cap;
		ring[head] = w;
		words++;
	endfunction

	function automatic logic [31:0] take_word(int unsigned cap);
		logic [31:0] w;
		w = ring[head % cap];
		head = (head + 1) % cap;
		words--;
		return w;
	endfunction

	function automatic twd_result_t step_deque(logic [2:0] k, logic [30:0] fn, logic [31:0] arg);
		int unsigned cap;
		int unsigned freew;
		logic [31:0] tag_word;
		logic [31:0] w;
		twd_result_t r;
		r = '0;
		r.status = ST_PUSHED;
		cap = (capacity < 2) ? 2 : ((capacity > TWD_MAX_DEPTH) ? TWD_MAX_DEPTH : capacity);
		head = head % cap;
		freew = (words < cap) ? cap - words : 0;
		tag_word = 32'd0 - {1'b0, fn};
		if (k <= OP_PUSH_FRONT_ARG) begin
			if (freew < (k[0] ? 2 : 1)) begin
				r.status = ST_FULL;
			end else begin
				case (k)
					OP_PUSH_BACK: begin
						put_back(cap, {1'b0, fn});
					end
					OP_PUSH_BACK_ARG: begin
						put_back(cap, tag_word);
						put_back(cap, arg);
					end
					OP_PUSH_FRONT: begin
						put_front(cap, {1'b0, fn});
					end
					default: begin
						// handle word must end up ahead of its argument
						put_front(cap, arg);
						put_front(cap, tag_word);
					end
				endcase
			end
		end else if (words == 0) begin
			r.status = ST_EMPTY;
		end else begin
			w = take_word(cap);
			r.status = ST_DISPATCHED;
			if (w != 0 && !w[31]) begin
				r.handle = w[30:0];
			end else begin
				w = 32'd0 - w;
				r.handle = w[30:0];
				if (words > 0) begin
					r.argument = take_word(cap);
					r.has_argument = 1'b1;
				end
			end
		end
		r.occupancy = words[8:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			words = 0;
			capacity = CAPACITY_RESET;
			errs = 0;
			results_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (results_q.size() == 0) begin
					$error("result with no item outstanding, status %0d", status);
					errs++;
				end else begin
					want = results_q.pop_front();
					check_field("status", want.status, status);
					check_field("out_handle", want.handle, out_handle);
					check_field("out_argument", want.argument, out_argument);
					check_field("has_argument", want.has_argument, has_argument);
					check_field("occupancy", want.occupancy, occupancy);
				end
			end
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == CFG_IDX_CAPACITY)
				capacity = pwdata[8:0];
			if (req_valid && !req_stall)
				results_q.push_back(step_deque(kind, fn_handle, argument));
			pending <= results_q.size();
			fail_count <= errs;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top: clock, reset, item and register stimulus, final verdict.
`timescale 1ns / 1ps
module testbench;
	import twd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [2:0] kind = '0;
	logic [30:0] fn_handle = '0;
	logic signed [31:0] argument = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [1:0] status;
	logic [30:0] out_handle;
	logic signed [31:0] out_argument;
	logic has_argument;
	logic [8:0] occupancy;

	logic req_taken = 1'b0;
	logic quiet = 1'b0;
	int fail_count;
	int pending;

	tagged_work_item_deque_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .fn_handle(fn_handle), .argument(argument),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .out_handle(out_handle), .out_argument(out_argument),
		.has_argument(has_argument), .occupancy(occupancy)
	);

	twd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .fn_handle(fn_handle), .argument(argument),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .out_handle(out_handle), .out_argument(out_argument),
		.has_argument(has_argument), .occupancy(occupancy),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		req_taken <= req_valid && !req_stall;
	end

	always @(negedge clk) begin
		rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 6);
	end

	task automatic write_capacity(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {CFG_IDX_CAPACITY, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_item(input logic [2:0] k, input logic [30:0] fn, input logic [31:0] arg);
		while (!quiet && $urandom_range(0, 99) < 6) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		fn_handle <= fn;
		argument <= arg;
		do @(negedge clk); while (!req_taken);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [30:0] pick_handle();
		case ($urandom_range(0, 19))
			0: return 31'd1;
			1: return '1;
			2: return '0;
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_argument();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_kind(int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) return 3'(OP_SCHEDULE) + 3'($urandom_range(1, 3));
		if (roll < push_pct) return 3'($urandom_range(0, 3));
		return OP_SCHEDULE;
	endfunction

	initial begin
		int caps[10];
		int push_pct;
		caps = '{2, 3, 1, 256, 511, 5, 0, 130, 4, 300};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// write every ring slot once so later capacity changes only expose written words
		for (int i = 0; i < TWD_MAX_DEPTH; i++)
			send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_handle(), $urandom);
		send_item(OP_PUSH_BACK, pick_handle(), pick_argument());
		send_item(OP_PUSH_BACK_ARG, pick_handle(), pick_argument());
		send_item(OP_PUSH_FRONT, pick_handle(), pick_argument());
		send_item(OP_PUSH_FRONT_ARG, pick_handle(), pick_argument());
		for (int i = 0; i <= TWD_MAX_DEPTH; i++)
			send_item(pick_kind(0), pick_handle(), pick_argument());
		wait_drained();

		// directed: clamped capacities, full and empty ring, zero handle, lone tagged word
		write_capacity(32'd0);
		send_item(OP_PUSH_BACK_ARG, 31'd1, 32'h8000_0000);
		send_item(OP_PUSH_BACK, '1, 32'h1234_5678);
		send_item(OP_PUSH_FRONT_ARG, 31'd5, '0);
		send_item(OP_SCHEDULE, '1, '1);
		send_item(3'(OP_SCHEDULE) + 3'd1, '0, '0);
		send_item(OP_PUSH_FRONT_ARG, '1, 32'h7FFF_FFFF);
		send_item(3'(OP_SCHEDULE) + 3'd2, '0, '0);
		send_item(OP_PUSH_BACK, '0, '1);
		send_item(3'(OP_SCHEDULE) + 3'd3, '0, '0);
		send_item(OP_PUSH_BACK, '0, '0);
		send_item(OP_PUSH_BACK, 31'h5555_5555, '0);
		send_item(OP_SCHEDULE, '0, '0);
		send_item(OP_PUSH_FRONT, 31'd1, '0);
		send_item(OP_SCHEDULE, '0, '0);
		wait_drained();
		write_capacity(32'd1);
		send_item(OP_PUSH_BACK_ARG, 31'h2AAA_AAAA, 32'h5555_5555);
		send_item(OP_PUSH_FRONT, 31'd7, '0);
		send_item(OP_SCHEDULE, '0, '0);
		wait_drained();
		write_capacity(32'd511);
		send_item(OP_PUSH_BACK_ARG, 31'h2AAA_AAAA, 32'h7FFF_FFFF);
		send_item(OP_PUSH_BACK, 31'd3, '0);
		send_item(OP_PUSH_FRONT, 31'd4, '0);
		wait_drained();
		// shrink while holding items: words may reorder or vanish
		write_capacity(32'd3);
		repeat (4) send_item(OP_SCHEDULE, '0, '0);
		wait_drained();

		for (int ph = 0; ph < 14; ph++) begin
			write_capacity(ph < 10 ? caps[ph] : $urandom_range(0, 511));
			quiet <= (ph >= 5 && ph < 8);
			push_pct = $urandom_range(35, 70);
			for (int i = 0; i < 40; i++)
				send_item(pick_kind(push_pct), pick_handle(), pick_argument());
			wait_drained();
		end
		quiet <= 1'b0;

		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== tagged_work_item_deque_top.f =====
hdl/twd_pkg.sv
hdl/twd_ram.sv
hdl/twd_front.sv
hdl/twd_queue.sv
hdl/twd_back.sv
hdl/tagged_work_item_deque_top.sv
tb/sv/twd_checker.sv
tb/sv/testbench.sv
